// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define RFBC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rfbc assertion failed");
// cond must never be true outside reset
`define RFBC_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rfbc forbidden condition seen");
`else
`define RFBC_ASSERT(label, clk, rst_n, prop)
`define RFBC_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/rfbc_pkg.sv -----
`default_nettype none
package rfbc_pkg;
	localparam int RES_W          = 60;
	localparam int WORD_W         = 64;
	localparam int SEL_W          = 3;
	localparam int IDX_W          = 6;
	localparam int PIDX_W         = 4;
	localparam int RESIDUE_FIELDS = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 4;
	localparam int IN_CNT_W       = 3;
	localparam int OUT_CNT_W      = 4;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	localparam logic [SEL_W-1:0] TS_IN_PRIME   = 3'd0;
	localparam logic [SEL_W-1:0] TS_IN_INV     = 3'd1;
	localparam logic [SEL_W-1:0] TS_IN_FACTOR  = 3'd2;
	localparam logic [SEL_W-1:0] TS_IN_SHIFT   = 3'd3;
	localparam logic [SEL_W-1:0] TS_OUT_PRIME  = 3'd4;
	localparam logic [SEL_W-1:0] TS_OUT_FACTOR = 3'd5;
	localparam logic [SEL_W-1:0] TS_OUT_SHIFT  = 3'd6;
	localparam logic [SEL_W-1:0] TS_CROSS      = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 1'b1;
endpackage
`default_nettype wire

// ----- src/rfbc_if.sv -----
`default_nettype none
// input word channel
interface rfbc_in_if import rfbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [SEL_W-1:0]  table_select;
	logic [IDX_W-1:0]  table_index;
	logic [WORD_W-1:0] word_low;
	logic [WORD_W-1:0] word_high;
	logic [RES_W-1:0]  residue_0;
	logic [RES_W-1:0]  residue_1;
	logic [RES_W-1:0]  residue_2;
	logic [RES_W-1:0]  residue_3;
	modport source (output valid, kind, table_select, table_index, word_low, word_high,
		residue_0, residue_1, residue_2, residue_3, input ready);
	modport sink (input valid, kind, table_select, table_index, word_low, word_high,
		residue_0, residue_1, residue_2, residue_3, output ready);
endinterface

// result word channel
interface rfbc_out_if import rfbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PIDX_W-1:0] prime_index;
	logic [RES_W-1:0]  residue;
	logic              last;
	modport source (output valid, prime_index, residue, last, input ready);
	modport sink (input valid, prime_index, residue, last, output ready);
endinterface
`default_nettype wire

// ----- src/rfbc_lane.sv -----
`default_nettype none
// Bit-serial modular multiplier: reduces a mod m, then r = a*b mod m, one bit a cycle.
module rfbc_lane #(
	parameter int RB = 60
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [RB-1:0] a,
	input  wire logic [RB-1:0] b,
	input  wire logic [RB-1:0] m,
	output logic               done,
	output logic [RB-1:0]      result
);
	localparam int CW = $clog2(RB);
	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_RED  = 2'd1;
	localparam logic [1:0] P_MUL  = 2'd2;

	logic [1:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RB-1:0] r_q, a_q, b_q, m_q;
	logic [RB:0]   red2, dbl, add;
	logic [RB-1:0] red_n, dbl_n, add_n, mul_n;

	always_comb begin
		red2  = {r_q, a_q[RB-1]};
		red_n = (red2 >= {1'b0, m_q}) ? RB'(red2 - {1'b0, m_q}) : RB'(red2);
		dbl   = {r_q, 1'b0};
		dbl_n = (dbl >= {1'b0, m_q}) ? RB'(dbl - {1'b0, m_q}) : RB'(dbl);
		add   = {1'b0, dbl_n} + {1'b0, a_q};
		add_n = (add >= {1'b0, m_q}) ? RB'(add - {1'b0, m_q}) : RB'(add);
		mul_n = b_q[RB-1] ? add_n : dbl_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				phase_q <= P_RED;
				cnt_q   <= CW'(RB - 1);
			end else begin
				unique case (phase_q)
					P_RED: begin
						if (cnt_q == '0) begin
							phase_q <= P_MUL;
							cnt_q   <= CW'(RB - 1);
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
					P_MUL: begin
						if (cnt_q == '0) begin
							phase_q <= P_IDLE;
							done_q  <= 1'b1;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (phase_q == P_RED) begin
			if (cnt_q == '0) begin
				a_q <= red_n;
				r_q <= '0;
			end else begin
				a_q <= a_q << 1;
				r_q <= red_n;
			end
		end else if (phase_q == P_MUL) begin
			r_q <= mul_n;
			b_q <= b_q << 1;
		end
	end

	assign done   = done_q;
	assign result = (m_q == '0) ? '0 : r_q;
endmodule
`default_nettype wire

// ----- src/rns_fast_base_conversion.sv -----
`default_nettype none
// RNS fast base conversion, one coefficient per convert word. Load words (kind 0)
// write at most one table entry; only input primes, input inverses, output primes
// and the cross table are kept. A convert word runs in four lanes, one per input
// prime, each a bit-serial modular multiplier: first y_i = x_i*inv_i mod q_i, then
// per output prime p_j the lanes form (y_i mod p_j)*cross[i][j] mod p_j and a merge
// stage adds the lane terms mod p_j one lane a cycle. Cross factors are fetched
// from a table with one read port one lane a cycle. Each multiply reduces the
// operand, then multiplies a bit a cycle. Result words go out in prime order; last
// marks the final prime. A new word is taken only after the last result word of
// the previous one has been taken.
`include "assert_macros.svh"
module rns_fast_base_conversion import rfbc_pkg::*; #(
	parameter int MAX_IN_PRIMES  = 4,
	parameter int MAX_OUT_PRIMES = 15,
	parameter int RESIDUE_BITS   = 60
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rfbc_in_if.sink                    item,
	rfbc_out_if.source                 result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int RB    = RESIDUE_BITS;
	localparam int NLANE = (MAX_IN_PRIMES < RESIDUE_FIELDS) ? MAX_IN_PRIMES : RESIDUE_FIELDS;
	localparam int LW    = (NLANE > 1) ? $clog2(NLANE) : 1;
	localparam int IW    = (MAX_IN_PRIMES > 1) ? $clog2(MAX_IN_PRIMES) : 1;
	localparam int OW    = (MAX_OUT_PRIMES > 1) ? $clog2(MAX_OUT_PRIMES) : 1;
	localparam int CD    = MAX_IN_PRIMES * MAX_OUT_PRIMES;
	localparam int CW    = (CD > 1) ? $clog2(CD) : 1;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_YMUL   = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_MSTART = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_MERGE  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	// tables, contents undefined until loaded
	logic [RB-1:0] in_prime_q [MAX_IN_PRIMES];
	logic [RB-1:0] in_inv_q   [MAX_IN_PRIMES];
	logic [RB-1:0] out_prime_q[MAX_OUT_PRIMES];
	logic [RB-1:0] cross_mem  [CD];
	logic [RB-1:0] cross_rd_q;

	logic [2:0]           state_q;
	logic [IN_CNT_W-1:0]  in_count_q, ni_q, ni_eff, k_q;
	logic [OUT_CNT_W-1:0] out_count_q, no_q, no_eff, j_q;
	logic [RB-1:0]        y_q[NLANE];
	logic [RB-1:0]        c_q[NLANE];
	logic [RB-1:0]        p_q, sum_q, term, merge_sum;
	logic [RB:0]          merge_raw;
	logic [7:0]           addr_full;
	logic [CW-1:0]        rd_addr;
	logic                 accept, is_last;

	logic [RES_W-1:0] res_in[RESIDUE_FIELDS];
	logic             lane_start;
	logic             lane_done[NLANE];
	logic             lanes_done;
	logic [RB-1:0]    lane_a[NLANE], lane_b[NLANE], lane_m[NLANE], lane_res[NLANE];

	assign res_in[0] = item.residue_0;
	assign res_in[1] = item.residue_1;
	assign res_in[2] = item.residue_2;
	assign res_in[3] = item.residue_3;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign is_last    = (j_q == no_q - 1'b1);

	// counts saturate at what the block can hold
	assign ni_eff = (in_count_q > IN_CNT_W'(NLANE)) ? IN_CNT_W'(NLANE) : in_count_q;
	assign no_eff = (int'(out_count_q) > MAX_OUT_PRIMES) ? OUT_CNT_W'(MAX_OUT_PRIMES)
		: out_count_q;

	// cross entry i*no+j for the lane being fetched
	assign addr_full = 8'(k_q) * 8'(no_q) + 8'(j_q);
	assign rd_addr   = CW'(addr_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= IN_CNT_W'(1);
			out_count_q <= OUT_CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IN_COUNT:  in_count_q  <= cfg_data[IN_CNT_W-1:0];
				CFG_OUT_COUNT: out_count_q <= cfg_data[OUT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// table loads
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_LOAD) begin
			unique case (item.table_select)
				TS_IN_PRIME:
					if (int'(item.table_index) < MAX_IN_PRIMES)
						in_prime_q[IW'(item.table_index)] <= RB'(item.word_low);
				TS_IN_INV:
					if (int'(item.table_index) < MAX_IN_PRIMES)
						in_inv_q[IW'(item.table_index)] <= RB'(item.word_low);
				TS_OUT_PRIME:
					if (int'(item.table_index) < MAX_OUT_PRIMES)
						out_prime_q[OW'(item.table_index)] <= RB'(item.word_low);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_LOAD && item.table_select == TS_CROSS
			&& int'(item.table_index) < CD)
			cross_mem[CW'(item.table_index)] <= RB'(item.word_low);
		cross_rd_q <= cross_mem[rd_addr];
	end

	// lanes: first pass x*inv mod q, later passes y*cross mod p
	assign lane_start = (accept && item.kind == KIND_CONVERT) || (state_q == S_MSTART);

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		assign lane_a[l] = (state_q == S_IDLE) ? RB'(res_in[l]) : y_q[l];
		assign lane_b[l] = (state_q == S_IDLE) ? in_inv_q[l] : c_q[l];
		assign lane_m[l] = (state_q == S_IDLE) ? in_prime_q[l] : p_q;

		rfbc_lane #(.RB(RB)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.a      (lane_a[l]),
			.b      (lane_b[l]),
			.m      (lane_m[l]),
			.done   (lane_done[l]),
			.result (lane_res[l])
		);
	end

	// all lanes start together, so they finish together
	always_comb begin
		lanes_done = 1'b1;
		for (int l = 0; l < NLANE; l++)
			lanes_done = lanes_done && lane_done[l];
	end

	// merge: running sum of lane terms mod p
	assign term      = lane_res[LW'(k_q)];
	assign merge_raw = {1'b0, sum_q} + {1'b0, term};
	assign merge_sum = (merge_raw >= {1'b0, p_q}) ? RB'(merge_raw - {1'b0, p_q})
		: RB'(merge_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ni_q    <= '0;
			no_q    <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.kind == KIND_CONVERT) begin
						ni_q    <= ni_eff;
						no_q    <= no_eff;
						state_q <= S_YMUL;
					end
				end
				S_YMUL: begin
					if (lanes_done) begin
						j_q <= '0;
						k_q <= '0;
						if (no_q == '0)
							state_q <= S_IDLE;
						else if (ni_q == '0)
							state_q <= S_OUT;
						else
							state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (k_q == ni_q)
						state_q <= S_MSTART;
					else
						k_q <= k_q + 1'b1;
				end
				S_MSTART: state_q <= S_MUL;
				S_MUL: begin
					if (lanes_done) begin
						k_q     <= '0;
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					k_q <= k_q + 1'b1;
					if (k_q == ni_q - 1'b1)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (result.ready) begin
						k_q <= '0;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + 1'b1;
							if (ni_q != '0)
								state_q <= S_FETCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_YMUL && lanes_done) begin
			for (int l = 0; l < NLANE; l++)
				y_q[l] <= lane_res[l];
		end
		if (state_q == S_FETCH) begin
			p_q <= out_prime_q[OW'(j_q)];
			for (int l = 0; l < NLANE; l++)
				if (k_q == IN_CNT_W'(l + 1))
					c_q[l] <= cross_rd_q;
		end
		if (state_q == S_MERGE)
			sum_q <= merge_sum;
		else if (state_q != S_OUT)
			sum_q <= '0;
	end

	assign result.valid       = (state_q == S_OUT);
	assign result.prime_index = PIDX_W'(j_q);
	assign result.residue     = RES_W'(sum_q);
	assign result.last        = is_last;

	`RFBC_NEVER(a_no_overlap, clk, arst_n, item.ready && result.valid)
	`RFBC_ASSERT(a_last_idx, clk, arst_n, result.valid && result.last |-> result.prime_index == PIDX_W'(no_q - 1'b1))
	`RFBC_ASSERT(a_back_idle, clk, arst_n, result.valid && result.ready && result.last |=> item.ready)
	`RFBC_ASSERT(a_reduced, clk, arst_n, result.valid && ni_q != '0 && p_q != '0 |-> sum_q < p_q)
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import rfbc_pkg::*;

	localparam int N_IN       = 4;
	localparam int N_OUT      = 15;
	localparam int CROSS_N    = N_IN * N_OUT;
	localparam int IN_IW      = $clog2(N_IN);
	localparam int OUT_IW     = $clog2(N_OUT);
	// covers a convert word with no output primes that is still in flight
	localparam int QUIET      = 300;
	// slowest run: every word at 15 primes plus stalls, several times over
	localparam int CYCLE_CAP  = 4_000_000;

	typedef struct packed {
		logic              kind;
		logic [SEL_W-1:0]  sel;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic [3:0][RES_W-1:0] res;
	} word_t;

	typedef struct packed {
		logic [PIDX_W-1:0] pidx;
		logic [RES_W-1:0]  residue;
		logic              last;
	} conv_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rfbc_in_if  in_ch ();
	rfbc_out_if out_ch ();

	rns_fast_base_conversion dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: only the tables that feed the result are mirrored
	// (Barrett factor and shift loads are dropped by the block)
	logic [RES_W-1:0] q_prime [N_IN];
	logic [RES_W-1:0] q_inv   [N_IN];
	logic [RES_W-1:0] p_prime [N_OUT];
	logic [RES_W-1:0] cross_f [CROSS_N];
	logic [IN_CNT_W-1:0]  in_cnt;
	logic [OUT_CNT_W-1:0] out_cnt;

	conv_res_t residue_q[$];

	int  errors;
	int  n_loads, n_converts, n_results;
	int  cycles;
	bit  idle_en;
	int  hold_len;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("TIMEOUT after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [RES_W-1:0] mul_mod(logic [63:0] a, logic [63:0] b,
		logic [63:0] m);
		logic [127:0] prod;
		if (m == 0)
			return '0;
		prod = {64'd0, a % m} * {64'd0, b % m};
		return RES_W'(prod % {64'd0, m});
	endfunction

	// mirror one accepted word: load updates tables, convert queues its residues
	task automatic predict_word(input word_t w);
		logic [RES_W-1:0] y [N_IN];
		logic [63:0] sum, t, p;
		int ni, no, ci;
		conv_res_t r;
		if (w.kind == KIND_LOAD) begin
			n_loads++;
			case (w.sel)
				TS_IN_PRIME:  if (w.idx < N_IN)    q_prime[IN_IW'(w.idx)] = w.lo[RES_W-1:0];
				TS_IN_INV:    if (w.idx < N_IN)    q_inv[IN_IW'(w.idx)]   = w.lo[RES_W-1:0];
				TS_OUT_PRIME: if (w.idx < N_OUT)   p_prime[OUT_IW'(w.idx)] = w.lo[RES_W-1:0];
				TS_CROSS:     if (w.idx < CROSS_N) cross_f[w.idx] = w.lo[RES_W-1:0];
				default: ;
			endcase
			return;
		end
		n_converts++;
		ni = (int'(in_cnt) > N_IN) ? N_IN : int'(in_cnt);
		no = (int'(out_cnt) > N_OUT) ? N_OUT : int'(out_cnt);
		for (int i = 0; i < ni; i++)
			y[i] = mul_mod(64'(w.res[i]), 64'(q_inv[i]), 64'(q_prime[i]));
		for (int j = 0; j < no; j++) begin
			p   = 64'(p_prime[j]);
			sum = '0;
			for (int i = 0; i < ni; i++) begin
				ci = i * no + j;
				t = 64'(mul_mod(64'(y[i]), (ci < CROSS_N) ? 64'(cross_f[ci]) : 64'd0, p));
				sum += t;
				if (sum >= p)
					sum -= p;
			end
			r.pidx    = PIDX_W'(j);
			r.residue = sum[RES_W-1:0];
			r.last    = (j + 1 == no);
			residue_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		errors++;
		$display("MISMATCH %s: expected %0h, got %0h (cycle %0d)", what, exp_v, got_v,
			cycles);
	endtask

	// result checker
	always @(posedge clk) begin
		conv_res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (residue_q.size() == 0) begin
				report_mismatch("unexpected result word", 64'd0, 64'(out_ch.residue));
			end else begin
				e = residue_q.pop_front();
				if (out_ch.prime_index !== e.pidx)
					report_mismatch("prime_index", 64'(e.pidx), 64'(out_ch.prime_index));
				if (out_ch.residue !== e.residue)
					report_mismatch("residue", 64'(e.residue), 64'(out_ch.residue));
				if (out_ch.last !== e.last)
					report_mismatch("last", 64'(e.last), 64'(out_ch.last));
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				out_ch.ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// send one word; valid stays high for back-to-back words
	task automatic send_word(input word_t w);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.kind         <= w.kind;
		in_ch.table_select <= w.sel;
		in_ch.table_index  <= w.idx;
		in_ch.word_low     <= w.lo;
		in_ch.word_high    <= w.hi;
		in_ch.residue_0    <= w.res[0];
		in_ch.residue_1    <= w.res[1];
		in_ch.residue_2    <= w.res[2];
		in_ch.residue_3    <= w.res[3];
		in_ch.valid        <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		predict_word(w);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// moduli: mostly full width, some small, rare zero or all ones
	function automatic logic [63:0] rand_modulus();
		case ($urandom_range(0, 9))
			0:       return 64'd0;
			1:       return {4'h0, {RES_W{1'b1}}};
			2, 3:    return 64'($urandom_range(2, 5000));
			default: return rand64();
		endcase
	endfunction

	task automatic send_load(input logic [SEL_W-1:0] sel, input int idx,
		input logic [63:0] lo);
		word_t w;
		w = '0;
		w.kind = KIND_LOAD;
		w.sel  = sel;
		w.idx  = IDX_W'(idx);
		w.lo   = lo;
		w.hi   = rand64();
		// ignored on a load
		w.res  = {RES_W'(rand64()), RES_W'(rand64()), RES_W'(rand64()), RES_W'(rand64())};
		send_word(w);
	endtask

	task automatic send_convert(input logic [RES_W-1:0] r0, input logic [RES_W-1:0] r1,
		input logic [RES_W-1:0] r2, input logic [RES_W-1:0] r3);
		word_t w;
		w      = '0;
		w.kind = KIND_CONVERT;
		w.sel  = SEL_W'($urandom);
		w.idx  = IDX_W'($urandom);
		w.lo   = rand64();
		w.hi   = rand64();
		w.res  = {r3, r2, r1, r0};
		send_word(w);
	endtask

	task automatic send_random_convert();
		send_convert(RES_W'(rand64()), RES_W'(rand64()), RES_W'(rand64()),
			RES_W'(rand64()));
	endtask

	// drain, let the pipe settle, then write a count register
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (residue_q.size() != 0) @(posedge clk);
		repeat (QUIET) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IN_COUNT)
			in_cnt = val[IN_CNT_W-1:0];
		else
			out_cnt = val;
	endtask

	task automatic set_counts(input int ni, input int no);
		write_cfg(CFG_IN_COUNT, CFG_DATA_W'(ni));
		write_cfg(CFG_OUT_COUNT, CFG_DATA_W'(no));
	endtask

	// every entry that a convert can read gets written first; Barrett and shift
	// tables get a word too, then out-of-range indexes that must be dropped
	task automatic test_table_fill();
		for (int i = 0; i < N_IN; i++) begin
			send_load(TS_IN_PRIME, i, rand_modulus());
			send_load(TS_IN_INV, i, rand64());
			send_load(TS_IN_FACTOR, i, rand64());
			send_load(TS_IN_SHIFT, i, rand64());
		end
		for (int j = 0; j < N_OUT; j++) begin
			send_load(TS_OUT_PRIME, j, rand_modulus());
			send_load(TS_OUT_FACTOR, j, rand64());
			send_load(TS_OUT_SHIFT, j, rand64());
		end
		for (int k = 0; k < CROSS_N; k++)
			send_load(TS_CROSS, k, rand64());
		send_load(TS_IN_PRIME, N_IN, rand64());
		send_load(TS_IN_INV, 63, rand64());
		send_load(TS_OUT_PRIME, N_OUT, rand64());
		send_load(TS_CROSS, CROSS_N, rand64());
		send_load(TS_CROSS, 63, rand64());
	endtask

	task automatic test_directed();
		logic [RES_W-1:0] ones;
		ones = '1;
		// widest setting, field extremes
		set_counts(N_IN, N_OUT);
		send_convert('0, '0, '0, '0);
		send_convert(ones, ones, ones, ones);
		send_convert({15{4'hA}}, {15{4'h5}}, {15{4'hA}}, {15{4'h5}});
		// smallest setting
		set_counts(1, 1);
		send_convert(ones, '0, ones, '0);
		// no input primes: every sum is zero
		set_counts(0, 3);
		send_random_convert();
		// in_count beyond the table saturates
		set_counts(7, 2);
		send_random_convert();
		// no output primes: nothing comes back
		set_counts(N_IN, 0);
		send_random_convert();
		// zero moduli on both sides
		send_load(TS_IN_PRIME, 1, 64'd0);
		send_load(TS_OUT_PRIME, 0, 64'd0);
		set_counts(N_IN, 4);
		send_random_convert();
		// unreduced residue, inverse and cross factor against tiny moduli
		send_load(TS_IN_PRIME, 0, 64'd7);
		send_load(TS_IN_INV, 0, rand64() | 64'hFFF);
		send_load(TS_OUT_PRIME, 0, 64'd13);
		send_load(TS_CROSS, 0, 64'({RES_W{1'b1}}));
		send_load(TS_IN_PRIME, 1, rand_modulus());
		set_counts(1, 4);
		send_convert(ones, '0, '0, '0);
		send_convert(RES_W'(6), '0, '0, '0);
	endtask

	// receiver stops for a long stretch while words keep coming
	task automatic test_backpressure();
		set_counts(N_IN, 3);
		hold_len = 600;
		repeat (6) send_random_convert();
	endtask

	task automatic test_random(input int n_items, input int n_phases);
		int sel;
		for (int ph = 0; ph < n_phases; ph++) begin
			if ($urandom_range(0, 9) < 7)
				set_counts($urandom_range(1, N_IN), $urandom_range(1, 4));
			else
				set_counts($urandom_range(0, 7), $urandom_range(0, N_OUT));
			for (int k = 0; k < n_items / n_phases; k++) begin
				if ($urandom_range(0, 9) < 8) begin
					send_random_convert();
				end else begin
					sel = $urandom_range(0, 7);
					send_load(SEL_W'(sel), $urandom_range(0, 63),
						(sel == TS_IN_PRIME || sel == TS_OUT_PRIME) ? rand_modulus()
							: rand64());
				end
			end
		end
	endtask

	initial begin
		errors = 0; n_loads = 0; n_converts = 0; n_results = 0;
		cycles = 0; hold_len = 0; idle_en = 1'b1;
		in_cnt = IN_CNT_W'(1); out_cnt = OUT_CNT_W'(1);
		for (int i = 0; i < N_IN; i++) begin q_prime[i] = '0; q_inv[i] = '0; end
		for (int j = 0; j < N_OUT; j++) p_prime[j] = '0;
		for (int k = 0; k < CROSS_N; k++) cross_f[k] = '0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.kind         <= KIND_LOAD;
		in_ch.table_select <= TS_IN_PRIME;
		in_ch.table_index  <= '0;
		in_ch.word_low     <= '0;
		in_ch.word_high    <= '0;
		in_ch.residue_0    <= '0;
		in_ch.residue_1    <= '0;
		in_ch.residue_2    <= '0;
		in_ch.residue_3    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_directed();
		test_backpressure();
		test_random(120, 8);
		// last stretch runs with no idling on either side
		idle_en = 1'b0;
		test_random(40, 2);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (residue_q.size() != 0) @(posedge clk);
		repeat (QUIET) @(posedge clk);

		$display("Covered %0d table loads and %0d conversions, %0d result words checked,",
			n_loads, n_converts, n_results);
		$display("across count settings from zero to beyond range, with stalls on both sides.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", errors);
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

`default_nettype wire
